### rtl/hkra_pkg.sv
// ============================================================================
// hkra_pkg
// Types, constants and the usage-to-character table of the keyboard decoder.
// ============================================================================
package hkra_pkg;

   localparam int DEVICES_DEFAULT = 4;
   localparam int KEY_SLOTS       = 6;
   localparam int CODE_W          = 8;
   localparam int CHAR_W          = 7;
   localparam int DEV_W           = 2;

   localparam logic [CODE_W-1:0] LEFT_SHIFT_MASK  = 8'h02;
   localparam logic [CODE_W-1:0] RIGHT_SHIFT_MASK = 8'h20;
   localparam logic [CHAR_W-1:0] CASE_OFFSET      = 7'd32;
   localparam logic [CHAR_W-1:0] CHAR_LOWER_A     = 7'h61;
   localparam logic [CHAR_W-1:0] CHAR_LOWER_Z     = 7'h7A;

   typedef logic [KEY_SLOTS-1:0][CODE_W-1:0] key_set_type;

   // Characters of one report waiting to be sent, one valid bit per slot.
   typedef struct packed {
      logic [KEY_SLOTS-1:0]             mask;
      logic [KEY_SLOTS-1:0][CHAR_W-1:0] chars;
   } emit_load_type;

   // US QWERTY, unshifted; zero marks a code without a character.
   function automatic logic [CHAR_W-1:0] usage_to_ascii(input logic [CHAR_W-1:0] code);
      logic [CHAR_W-1:0] ch;
      case (code) inside
         [7'd4:7'd29]:  ch = CHAR_LOWER_A + (code - 7'd4);
         [7'd30:7'd38]: ch = 7'h31 + (code - 7'd30);
         7'd39:         ch = 7'h30;
         7'd40:         ch = 7'h0A;
         7'd42:         ch = 7'h08;
         7'd43:         ch = 7'h09;
         7'd44:         ch = 7'h20;
         7'd45:         ch = 7'h2D;
         7'd46:         ch = 7'h3D;
         7'd47:         ch = 7'h5B;
         7'd48:         ch = 7'h5D;
         7'd49:         ch = 7'h5C;
         7'd51:         ch = 7'h3B;
         7'd52:         ch = 7'h27;
         7'd53:         ch = 7'h60;
         7'd54:         ch = 7'h2C;
         7'd55:         ch = 7'h2E;
         7'd56:         ch = 7'h2F;
         default:       ch = '0;
      endcase
      return ch;
   endfunction

endpackage

### rtl/hid_keyboard_report_to_ascii_top.sv
// ============================================================================
// hid_keyboard_report_to_ascii_top
// Boot keyboard report decoder for several keyboards, US QWERTY layout.
// ============================================================================
// Each req transaction carries one boot keyboard report; every key that was
// not held in the previous report from the same keyboard and has a
// character is sent as one rsp transaction, lowest slot first, with tlast on
// the last character of the report. Reports from a device number at or above
// DEVICES are accepted and dropped. The output buffer sends one character per
// cycle while rsp_tready is high and takes the next report's characters in
// the cycle its last one leaves. A report's first character passes the scan
// stage registers, loaded with the key store read, and then the output
// buffer register. The key store resets with no clearing pass; each entry
// reads as empty until its keyboard's first report is written.
// ============================================================================
module hid_keyboard_report_to_ascii_top
   import hkra_pkg::*;
#(
   parameter int DEVICES = DEVICES_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // device_index[1:0], modifier_bits[9:2], key_code_0[17:10] .. key_code_5[57:50]
   input  logic [63:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // ascii_char[6:0]
   output logic [7:0]  rsp_tdata,
   output logic        rsp_tlast
);

   localparam int ADDR_W = (DEVICES > 1) ? $clog2(DEVICES) : 1;

   logic              accept;
   logic              in_range;
   logic [DEV_W-1:0]  req_dev;
   logic [CODE_W-1:0] req_mods;
   key_set_type       req_keys;
   logic [ADDR_W-1:0] req_addr;

   // Scan stage: the accepted report, scanned against its previous key codes while it waits for the output buffer.
   logic              a_valid_ff;
   logic              a_valid_in;
   logic [ADDR_W-1:0] a_addr_ff;
   logic              a_shift_ff;
   key_set_type       a_keys_ff;
   logic              a_retire;

   key_set_type       prev_keys;
   emit_load_type     scan_load;
   logic              emit_free;
   logic              emit_load_en;
   logic [CHAR_W-1:0] rsp_char;

   assign req_dev  = req_tdata[1:0];
   assign req_mods = req_tdata[9:2];
   assign req_keys = req_tdata[57:10];
   assign req_addr = ADDR_W'(req_dev);
   assign in_range = (int'(req_dev) < DEVICES);

   // The scan stage retires once its characters have a place in the output
   // buffer; a report with no new character retires at once.
   assign emit_load_en = a_valid_ff && (scan_load.mask != '0) && emit_free;
   assign a_retire     = a_valid_ff && ((scan_load.mask == '0) || emit_free);
   assign req_tready   = !a_valid_ff || a_retire;
   assign accept       = req_tvalid && req_tready;

   always_comb begin
      a_valid_in = a_valid_ff;
      if (accept) begin
         a_valid_in = in_range;
      end else if (a_retire) begin
         a_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         a_addr_ff  <= req_addr;
         a_shift_ff <= |(req_mods & (LEFT_SHIFT_MASK | RIGHT_SHIFT_MASK));
         a_keys_ff  <= req_keys;
      end
   end

   // Read the keyboard's previous codes as the report enters; write the new
   // codes back as it retires. The store forwards a write to a same-entry read.
   hkra_key_mem #(
      .DEVICES (DEVICES),
      .ADDR_W  (ADDR_W)
   ) u_key_mem (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (accept && in_range),
      .rd_addr (req_addr),
      .rd_keys (prev_keys),
      .wr_en   (a_retire),
      .wr_addr (a_addr_ff),
      .wr_keys (a_keys_ff)
   );

   hkra_scan u_scan (
      .cur_keys  (a_keys_ff),
      .prev_keys (prev_keys),
      .shift     (a_shift_ff),
      .load      (scan_load)
   );

   hkra_emit u_emit (
      .clock     (clock),
      .reset     (reset),
      .load_en   (emit_load_en),
      .load      (scan_load),
      .free      (emit_free),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_char  (rsp_char),
      .out_last  (rsp_tlast)
   );

   assign rsp_tdata = {1'b0, rsp_char};

endmodule

### rtl/hkra_key_mem.sv
// ============================================================================
// hkra_key_mem
// Per-keyboard store of the previous report's key codes, registered read.
// ============================================================================
module hkra_key_mem
   import hkra_pkg::*;
#(
   parameter int DEVICES = DEVICES_DEFAULT,
   parameter int ADDR_W  = (DEVICES > 1) ? $clog2(DEVICES) : 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output key_set_type       rd_keys,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  key_set_type       wr_keys
);

   key_set_type        mem [DEVICES];
   logic [DEVICES-1:0] valid_ff;
   logic [DEVICES-1:0] valid_in;
   key_set_type        rd_keys_ff;
   logic               rd_vld_ff;

   // An entry not yet written since reset reads as all zero.
   always_comb begin
      valid_in = valid_ff;
      if (wr_en) begin
         valid_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_keys;
      end
   end

   // A read that meets a write to the same entry takes the new data.
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff <= 1'b0;
      end else if (rd_en) begin
         rd_vld_ff <= (wr_en && wr_addr == rd_addr) ? 1'b1 : valid_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_keys_ff <= (wr_en && wr_addr == rd_addr) ? wr_keys : mem[rd_addr];
      end
   end

   assign rd_keys = rd_vld_ff ? rd_keys_ff : '0;

endmodule

### rtl/hkra_scan.sv
// ============================================================================
// hkra_scan
// Finds the newly pressed keys of a report and maps them to characters.
// ============================================================================
module hkra_scan
   import hkra_pkg::*;
(
   input  key_set_type   cur_keys,
   input  key_set_type   prev_keys,
   input  logic          shift,
   output emit_load_type load
);

   always_comb begin
      logic              held;
      logic [CHAR_W-1:0] ch;
      load = '0;
      for (int k = 0; k < KEY_SLOTS; k++) begin
         held = 1'b0;
         for (int j = 0; j < KEY_SLOTS; j++) begin
            if (prev_keys[j] == cur_keys[k]) begin
               held = 1'b1;
            end
         end
         ch = usage_to_ascii(cur_keys[k][CHAR_W-1:0]);
         if (shift && ch >= CHAR_LOWER_A && ch <= CHAR_LOWER_Z) begin
            ch = ch - CASE_OFFSET;
         end
         load.chars[k] = ch;
         // Codes of 128 and above have no character.
         load.mask[k]  = !cur_keys[k][CODE_W-1] && !held && (ch != '0);
      end
   end

endmodule

### rtl/hkra_emit.sv
// ============================================================================
// hkra_emit
// Output buffer that sends the characters of one report, lowest slot first.
// ============================================================================
module hkra_emit
   import hkra_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              load_en,
   input  emit_load_type     load,
   output logic              free,
   output logic              out_valid,
   input  logic              out_ready,
   output logic [CHAR_W-1:0] out_char,
   output logic              out_last
);

   logic [KEY_SLOTS-1:0]             mask_ff;
   logic [KEY_SLOTS-1:0]             mask_in;
   logic [KEY_SLOTS-1:0][CHAR_W-1:0] chars_ff;
   logic [KEY_SLOTS-1:0]             rest;

   assign rest      = mask_ff & (mask_ff - KEY_SLOTS'(1));
   assign out_valid = |mask_ff;
   assign out_last  = (rest == '0);
   assign free      = !out_valid || (out_last && out_ready);

   always_comb begin
      out_char = '0;
      for (int k = KEY_SLOTS - 1; k >= 0; k--) begin
         if (mask_ff[k]) begin
            out_char = chars_ff[k];
         end
      end
   end

   always_comb begin
      mask_in = mask_ff;
      if (load_en) begin
         mask_in = load.mask;
      end else if (out_valid && out_ready) begin
         mask_in = rest;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff <= '0;
      end else begin
         mask_ff <= mask_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_en) begin
         chars_ff <= load.chars;
      end
   end

endmodule
